// File: rtl/core/ttsc_pkg.sv
// Shared types, constants and helper functions of the teletype scroll engine.
package ttsc_pkg;

  localparam int unsigned MAX_COLS   = 132;
  localparam int unsigned MAX_ROWS   = 64;
  localparam int unsigned CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);

  localparam logic [15:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]  TTY_ATTR   = 8'h07;

  // Character codes
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Request opcodes
  localparam logic [2:0] OP_TTY     = 3'd0;
  localparam logic [2:0] OP_SCR_UP  = 3'd1;
  localparam logic [2:0] OP_SCR_DN  = 3'd2;
  localparam logic [2:0] OP_SET_CUR = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_MONO = 2'd2;

  typedef enum logic [3:0] {
    CMD_CR, CMD_LF, CMD_BS, CMD_TAB, CMD_BEL, CMD_PUT,
    CMD_SCROLL, CMD_SETCUR, CMD_READ
  } cmd_kind_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LF_RD, S_LF_WAIT, S_PUT_RD, S_PUT_WR,
    S_SETTLE, S_SC_CELL, S_SC_WR, S_OUT_RD, S_OUT_WAIT
  } back_st_e;

  // Screen geometry after clamping
  typedef struct packed {
    logic [7:0] cols;
    logic [6:0] rows;
    logic       mono;
  } scr_t;

  // Decoded request; x0/y0 double as the new cursor for set cursor
  typedef struct packed {
    cmd_kind_e  kind;
    logic       ignored;
    logic [7:0] ch;
    logic [7:0] x0;
    logic [5:0] y0;
    logic [7:0] x1;
    logic [5:0] y1;
    logic       up;
    logic [5:0] cnt;   // zero wipes the window
    logic [7:0] attr;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  cx;
    logic [5:0]  cy;
    logic [15:0] cell_data;
    logic        bell;
    logic        ignored;
  } res_t;

  function automatic scr_t clamp_scr(logic [7:0] cols, logic [6:0] rows, logic mono);
    scr_t s;
    s.cols = (cols == 8'd0) ? 8'd1 : ((cols > 8'(MAX_COLS)) ? 8'(MAX_COLS) : cols);
    s.rows = (rows == 7'd0) ? 7'd1 : ((rows > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows);
    s.mono = mono;
    return s;
  endfunction

  // Monochrome rule: a blank attribute other than 0 or 7 in its low bits gets |7
  function automatic logic [7:0] mono_fix(logic mono, logic [7:0] attr);
    logic [7:0] a;
    a = attr;
    if (mono && (attr[2:0] != 3'd0) && (attr[2:0] != 3'd7)) begin
      a = attr | 8'h07;
    end
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [7:0] x, logic [5:0] y,
                                                  logic [7:0] cols);
    logic [ADDR_W-1:0] p;
    p = ADDR_W'(y) * ADDR_W'(cols);
    return p + ADDR_W'(x);
  endfunction

endpackage

// File: rtl/core/text_mode_teletype_scroll_engine.sv
// Top level of the text-mode teletype and scroll engine.
// After reset the cell memory is cleared to blank cells (0x0720) in one pass, during which
// full stays high; configuration writes are taken throughout. Each request gives one result.
// Requests are executed one at a time against a cell memory with one write port and one
// registered read port, which sets the timing. An accepted request waits in the request
// queue until the executor is idle. A printable character reads and writes its cell, a line
// feed reads the cursor cell for its attribute, a tab writes spaces up to a column that is
// a multiple of 8, and a window scroll copies each moved cell and blanks the rest; a teletype
// scroll at the bottom line adds a scroll of the whole screen. A full result queue holds the
// executor. A two-entry queue on each side lets requests and results wait.
module text_mode_teletype_scroll_engine import ttsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] op_i,
  input  logic [7:0] char_code_i,
  input  logic [7:0] fill_attr_i,
  input  logic [7:0] line_count_i,
  input  logic [7:0] win_left_i,
  input  logic [7:0] win_top_i,
  input  logic [7:0] win_right_i,
  input  logic [7:0] win_bottom_i,
  input  logic [7:0] new_col_i,
  input  logic [7:0] new_row_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] cursor_x_o,
  output logic [5:0] cursor_y_o,
  output logic [7:0] cell_char_o,
  output logic [7:0] cell_attr_o,
  output logic       bell_o,
  output logic       ignored_o
);

  logic [7:0] cols_q;
  logic [6:0] rows_q;
  logic       mono_q;
  scr_t       scr;
  cmd_t       dec_cmd, q_cmd;
  logic       q_push, q_full, q_valid, q_pop, clearing, res_empty;
  res_t       res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 8'd80;
      rows_q <= 7'd25;
      mono_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLS: cols_q <= cfg_data_i;
        CFG_ROWS: rows_q <= cfg_data_i[6:0];
        CFG_MONO: mono_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign scr = clamp_scr(cols_q, rows_q, mono_q);

  ttsc_front u_front (
    .push_i       (push),
    .full_o       (full),
    .op_i         (op_i),
    .char_code_i  (char_code_i),
    .fill_attr_i  (fill_attr_i),
    .line_count_i (line_count_i),
    .win_left_i   (win_left_i),
    .win_top_i    (win_top_i),
    .win_right_i  (win_right_i),
    .win_bottom_i (win_bottom_i),
    .new_col_i    (new_col_i),
    .new_row_i    (new_row_i),
    .scr_i        (scr),
    .clearing_i   (clearing),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .cmd_o        (dec_cmd)
  );

  ttsc_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (dec_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd)
  );

  ttsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scr_i       (scr),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .clearing_o  (clearing),
    .res_empty_o (res_empty),
    .res_pop_i   (pop & ~res_empty),
    .res_o       (res)
  );

  assign empty       = res_empty;
  assign cursor_x_o  = res.cx;
  assign cursor_y_o  = res.cy;
  assign cell_char_o = res.cell_data[7:0];
  assign cell_attr_o = res.cell_data[15:8];
  assign bell_o      = res.bell;
  assign ignored_o   = res.ignored;

endmodule

// File: rtl/core/ttsc_front.sv
// Request decoder: accepts requests, clips scroll windows and classifies them.
module ttsc_front import ttsc_pkg::*; (
  input  logic       push_i,
  output logic       full_o,
  input  logic [2:0] op_i,
  input  logic [7:0] char_code_i,
  input  logic [7:0] fill_attr_i,
  input  logic [7:0] line_count_i,
  input  logic [7:0] win_left_i,
  input  logic [7:0] win_top_i,
  input  logic [7:0] win_right_i,
  input  logic [7:0] win_bottom_i,
  input  logic [7:0] new_col_i,
  input  logic [7:0] new_row_i,
  input  scr_t       scr_i,
  input  logic       clearing_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cmd_t       cmd_o
);

  logic [7:0] rows8;
  logic [7:0] x1c;
  logic [7:0] y1c;
  logic [7:0] dy;
  logic       reject;

  // Hold off requests during the clearing pass and while the queue is full
  assign full_o   = q_full_i | clearing_i;
  assign q_push_o = push_i & ~full_o;

  // Window clipping
  assign rows8  = {1'b0, scr_i.rows};
  assign x1c    = (win_right_i >= scr_i.cols) ? scr_i.cols - 8'd1 : win_right_i;
  assign y1c    = (win_bottom_i >= rows8) ? rows8 - 8'd1 : win_bottom_i;
  assign reject = (x1c < win_left_i) || (y1c < win_top_i);
  assign dy     = y1c - win_top_i + 8'd1;

  // Classification
  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = CMD_READ;
    cmd_o.ch   = char_code_i;
    unique case (op_i)
      OP_TTY: begin
        unique case (char_code_i)
          CH_CR:   cmd_o.kind = CMD_CR;
          CH_LF:   cmd_o.kind = CMD_LF;
          CH_BS:   cmd_o.kind = CMD_BS;
          CH_TAB:  cmd_o.kind = CMD_TAB;
          CH_BEL:  cmd_o.kind = CMD_BEL;
          default: cmd_o.kind = CMD_PUT;
        endcase
      end
      OP_SCR_UP, OP_SCR_DN: begin
        if (reject) begin
          cmd_o.ignored = 1'b1;
        end else begin
          cmd_o.kind = CMD_SCROLL;
          cmd_o.x0   = win_left_i;
          cmd_o.y0   = win_top_i[5:0];
          cmd_o.x1   = x1c;
          cmd_o.y1   = y1c[5:0];
          cmd_o.up   = (op_i == OP_SCR_UP);
          cmd_o.cnt  = (line_count_i >= dy) ? 6'd0 : line_count_i[5:0];
          cmd_o.attr = mono_fix(scr_i.mono, fill_attr_i);
        end
      end
      OP_SET_CUR: begin
        if ((new_col_i >= scr_i.cols) || (new_row_i >= rows8)) begin
          cmd_o.ignored = 1'b1;
        end else begin
          cmd_o.kind = CMD_SETCUR;
          cmd_o.x0   = new_col_i;
          cmd_o.y0   = new_row_i[5:0];
        end
      end
      default: cmd_o.kind = CMD_READ;
    endcase
  end

endmodule

// File: rtl/core/ttsc_cmdq.sv
// Two-entry request queue between decoder and executor.
module ttsc_cmdq import ttsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  cmd_t       ent_q [2];
  logic       wp_q;
  logic       rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = ent_q[rp_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= cmd_i;
    end
  end

  // Pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/core/ttsc_back.sv
// Executor: cell memory, cursor, teletype and scroll sequencer, result queue.
module ttsc_back import ttsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  scr_t scr_i,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic clearing_o,
  output logic res_empty_o,
  input  logic res_pop_i,
  output res_t res_o
);

  back_st_e          st_q, st_d;
  logic [ADDR_W-1:0] clr_q;
  logic [7:0]        cx_q;
  logic [5:0]        cy_q;
  logic              bell_q, ign_q, tab_q;
  logic [7:0]        ch_q, latt_q;
  logic [7:0]        sx0_q, sx1_q, sattr_q, wx_q;
  logic [5:0]        sy0_q, sy1_q, scnt_q, wy_q;
  logic              sup_q;

  logic [15:0]       mem_q [CELL_COUNT];
  logic [15:0]       rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr, cur_addr, walk_addr;
  logic [15:0]       mem_wdata;

  res_t              res_q [2];
  logic              rwp_q, rrp_q;
  logic [1:0]        res_cnt_q;
  logic              res_full, res_push;

  logic [7:0]        cxc;
  logic [5:0]        cyc;
  logic [6:0]        src_up;
  logic [5:0]        srcy;
  logic              copy, row_last, walk_last, advance;
  logic              wrap, need_scr;
  logic [6:0]        ny;
  logic [7:0]        ncx;

  // Cursor pulled back on screen before each request
  assign cxc = (cx_q >= scr_i.cols) ? scr_i.cols - 8'd1 : cx_q;
  assign cyc = ({1'b0, cy_q} >= scr_i.rows) ? 6'(scr_i.rows - 7'd1) : cy_q;

  // Window walker: copy from the source row while it lies inside the window
  assign src_up    = {1'b0, wy_q} + {1'b0, scnt_q};
  assign srcy      = sup_q ? src_up[5:0] : wy_q - scnt_q;
  assign copy      = (scnt_q != 6'd0) &&
                     (sup_q ? (src_up <= {1'b0, sy1_q})
                            : ({1'b0, wy_q} >= ({1'b0, sy0_q} + {1'b0, scnt_q})));
  assign row_last  = sup_q ? (wy_q == sy1_q) : (wy_q == sy0_q);
  assign walk_last = (wx_q == sx1_q) && row_last;
  assign advance   = ((st_q == S_SC_CELL) && !copy) || (st_q == S_SC_WR);

  // Cursor settling: wrap past the last column, scroll past the last row
  assign wrap     = (cx_q >= scr_i.cols);
  assign ny       = wrap ? {1'b0, cy_q} + 7'd1 : {1'b0, cy_q};
  assign ncx      = wrap ? 8'd0 : cx_q;
  assign need_scr = (ny >= scr_i.rows);

  assign cur_addr  = cell_addr(cx_q, cy_q, scr_i.cols);
  assign walk_addr = cell_addr(wx_q, wy_q, scr_i.cols);

  assign res_full    = (res_cnt_q == 2'd2);
  assign res_empty_o = (res_cnt_q == 2'd0);
  assign res_o       = res_q[rrp_q];
  assign clearing_o  = (st_q == S_CLEAR);

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_CLEAR:   if (clr_q == ADDR_W'(CELL_COUNT - 1)) st_d = S_IDLE;
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_LF:           st_d = S_LF_RD;
            CMD_PUT, CMD_TAB: st_d = S_PUT_RD;
            CMD_SCROLL:       st_d = S_SC_CELL;
            default:          st_d = S_OUT_RD;
          endcase
        end
      end
      S_LF_RD:   st_d = S_LF_WAIT;
      S_LF_WAIT: st_d = S_SETTLE;
      S_PUT_RD:  st_d = S_PUT_WR;
      S_PUT_WR:  st_d = S_SETTLE;
      S_SETTLE: begin
        if (need_scr)                         st_d = S_SC_CELL;
        else if (tab_q && ncx[2:0] != 3'd0)   st_d = S_PUT_RD;
        else                                  st_d = S_OUT_RD;
      end
      S_SC_CELL: begin
        if (copy)           st_d = S_SC_WR;
        else if (walk_last) st_d = S_OUT_RD;
      end
      S_SC_WR:   st_d = walk_last ? S_OUT_RD : S_SC_CELL;
      S_OUT_RD:  st_d = S_OUT_WAIT;
      S_OUT_WAIT: if (!res_full) st_d = S_IDLE;
      default:   st_d = S_IDLE;
    endcase
  end

  // Memory and handshake controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = walk_addr;
    mem_wdata = rdata_q;
    mem_raddr = cur_addr;
    cmd_pop_o = 1'b0;
    res_push  = 1'b0;
    unique case (st_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = BLANK_CELL;
      end
      S_IDLE:    cmd_pop_o = cmd_valid_i;
      S_PUT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_addr;
        mem_wdata = {rdata_q[15:8], ch_q};
      end
      S_SC_CELL: begin
        mem_raddr = cell_addr(wx_q, srcy, scr_i.cols);
        mem_we    = !copy;
        mem_wdata = {sattr_q, CH_SPACE};
      end
      S_SC_WR:   mem_we = 1'b1;
      S_OUT_WAIT: res_push = !res_full;
      default: ;
    endcase
  end

  // Cell memory, read data registered
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_CLEAR;
      clr_q <= '0;
      cx_q  <= 8'd0;
      cy_q  <= 6'd0;
    end else begin
      st_q <= st_d;
      if (st_q == S_CLEAR) clr_q <= clr_q + ADDR_W'(1);
      unique case (st_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            unique case (cmd_i.kind)
              CMD_CR: begin
                cx_q <= 8'd0;
                cy_q <= cyc;
              end
              CMD_BS: begin
                cx_q <= (cxc != 8'd0) ? cxc - 8'd1 : 8'd0;
                cy_q <= cyc;
              end
              CMD_SETCUR: begin
                cx_q <= cmd_i.x0;
                cy_q <= cmd_i.y0;
              end
              default: begin
                cx_q <= cxc;
                cy_q <= cyc;
              end
            endcase
          end
        end
        S_LF_WAIT: cx_q <= scr_i.cols;   // forces a wrap to the next line
        S_PUT_WR:  cx_q <= cx_q + 8'd1;
        S_SETTLE: begin
          cx_q <= ncx;
          cy_q <= need_scr ? 6'(scr_i.rows - 7'd1) : ny[5:0];
        end
        default: ;
      endcase
    end
  end

  // Request and walker payload
  always_ff @(posedge clk_i) begin
    if ((st_q == S_IDLE) && cmd_valid_i) begin
      bell_q  <= (cmd_i.kind == CMD_BEL);
      ign_q   <= cmd_i.ignored;
      tab_q   <= (cmd_i.kind == CMD_TAB);
      ch_q    <= (cmd_i.kind == CMD_TAB) ? CH_SPACE : cmd_i.ch;
      latt_q  <= TTY_ATTR;
      sx0_q   <= cmd_i.x0;
      sy0_q   <= cmd_i.y0;
      sx1_q   <= cmd_i.x1;
      sy1_q   <= cmd_i.y1;
      sup_q   <= cmd_i.up;
      scnt_q  <= cmd_i.cnt;
      sattr_q <= cmd_i.attr;
      wx_q    <= cmd_i.x0;
      wy_q    <= cmd_i.up ? cmd_i.y0 : cmd_i.y1;
    end
    if (st_q == S_LF_WAIT) begin
      latt_q <= rdata_q[15:8];
    end
    // Whole-screen scroll up by one line
    if ((st_q == S_SETTLE) && need_scr) begin
      sx0_q   <= 8'd0;
      sy0_q   <= 6'd0;
      sx1_q   <= scr_i.cols - 8'd1;
      sy1_q   <= 6'(scr_i.rows - 7'd1);
      sup_q   <= 1'b1;
      scnt_q  <= (scr_i.rows == 7'd1) ? 6'd0 : 6'd1;
      sattr_q <= mono_fix(scr_i.mono, latt_q);
      wx_q    <= 8'd0;
      wy_q    <= 6'd0;
    end
    if (advance) begin
      if (wx_q == sx1_q) begin
        wx_q <= sx0_q;
        if (!row_last) wy_q <= sup_q ? wy_q + 6'd1 : wy_q - 6'd1;
      end else begin
        wx_q <= wx_q + 8'd1;
      end
    end
  end

  // Result queue
  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[rwp_q] <= '{cx: cx_q, cy: cy_q, cell_data: rdata_q, bell: bell_q,
                        ignored: ign_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwp_q     <= 1'b0;
      rrp_q     <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (res_push)  rwp_q <= ~rwp_q;
      if (res_pop_i) rrp_q <= ~rrp_q;
      unique case ({res_push, res_pop_i})
        2'b10:   res_cnt_q <= res_cnt_q + 2'd1;
        2'b01:   res_cnt_q <= res_cnt_q - 2'd1;
        default: res_cnt_q <= res_cnt_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (cx_q < scr_i.cols) && ({1'b0, cy_q} < scr_i.rows))
    else $error("result with cursor off screen");
  a_no_pop_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_CLEAR) |-> !cmd_pop_o)
    else $error("request taken during clearing pass");
  a_res_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= 2'd2)
    else $error("result queue overflow");
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_waddr < ADDR_W'(CELL_COUNT)))
    else $error("cell write out of range");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench of the text-mode teletype and scroll engine.
module tb_top import ttsc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // One request as driven on the input ports
  typedef struct {
    logic [2:0] op;
    logic [7:0] ch;
    logic [7:0] attr;
    logic [7:0] cnt;
    logic [7:0] left;
    logic [7:0] top;
    logic [7:0] right;
    logic [7:0] bottom;
    logic [7:0] ncol;
    logic [7:0] nrow;
  } tty_req_t;

  // Cursor and cell view that one request produces
  typedef struct {
    logic [7:0] cx;
    logic [5:0] cy;
    logic [7:0] ch;
    logic [7:0] attr;
    logic       bell;
    logic       ignored;
  } screen_view_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [2:0] op_i = '0;
  logic [7:0] char_code_i = '0, fill_attr_i = '0, line_count_i = '0;
  logic [7:0] win_left_i = '0, win_top_i = '0, win_right_i = '0, win_bottom_i = '0;
  logic [7:0] new_col_i = '0, new_row_i = '0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] cursor_x_o, cell_char_o, cell_attr_o;
  logic [5:0] cursor_y_o;
  logic       bell_o, ignored_o;

  text_mode_teletype_scroll_engine u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow screen state
  logic [15:0]  shadow_cells [CELL_COUNT];
  int unsigned  cols_reg, rows_reg, mono_reg;
  int unsigned  cur_col, cur_row, scr_w, scr_h;

  screen_view_t pending_views [$];
  int unsigned  mismatches = 0;
  int unsigned  requests_sent = 0;
  int unsigned  views_checked = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;

  function automatic int unsigned cell_pos(int unsigned x, int unsigned y);
    int unsigned i;
    i = y * scr_w + x;
    return (i < CELL_COUNT) ? i : 0;
  endfunction

  function automatic void blank_line(int unsigned y, int unsigned x0, int unsigned x1,
                                     logic [15:0] blank);
    for (int unsigned x = x0; x <= x1; x++) shadow_cells[cell_pos(x, y)] = blank;
  endfunction

  function automatic void move_line(int unsigned dy, int unsigned sy, int unsigned x0,
                                    int unsigned x1);
    for (int unsigned x = x0; x <= x1; x++)
      shadow_cells[cell_pos(x, dy)] = shadow_cells[cell_pos(x, sy)];
  endfunction

  // Window scroll; returns 0 when the window is rejected
  function automatic bit scroll_shadow(int unsigned x0, int unsigned y0, int unsigned x1,
                                       int unsigned y1, bit up, int unsigned count,
                                       logic [7:0] att);
    logic [15:0] blank;
    int unsigned height;
    if (mono_reg != 0 && att[2:0] != 3'd0 && att[2:0] != 3'd7) att = att | 8'h07;
    blank = {att, CH_SPACE};
    if (x1 >= scr_w) x1 = scr_w - 1;
    if (y1 >= scr_h) y1 = scr_h - 1;
    if (x1 < x0 || y1 < y0) return 1'b0;
    height = y1 - y0 + 1;
    if (count >= height) count = 0;
    if (count == 0) begin
      for (int unsigned y = y0; y <= y1; y++) blank_line(y, x0, x1, blank);
    end else if (up) begin
      for (int unsigned y = y0; y + count <= y1; y++) move_line(y, y + count, x0, x1);
      for (int unsigned y = y1 - count + 1; y <= y1; y++) blank_line(y, x0, x1, blank);
    end else begin
      for (int unsigned y = y1; y >= y0 + count; y--) move_line(y, y - count, x0, x1);
      for (int unsigned y = y0; y < y0 + count; y++) blank_line(y, x0, x1, blank);
    end
    return 1'b1;
  endfunction

  // Wrap past the last column, scroll the screen past the last row
  function automatic void settle_shadow(logic [7:0] line_att);
    if (cur_col >= scr_w) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= scr_h) begin
      cur_row = scr_h - 1;
      void'(scroll_shadow(0, 0, scr_w - 1, scr_h - 1, 1'b1, 1, line_att));
    end
  endfunction

  function automatic void put_shadow(logic [7:0] c);
    int unsigned i;
    i = cell_pos(cur_col, cur_row);
    shadow_cells[i][7:0] = c;
    cur_col++;
  endfunction

  // Expected view after one request
  function automatic screen_view_t predict_view(tty_req_t r);
    screen_view_t v;
    logic [7:0]   line_att;
    logic [15:0]  cur_cell;
    v = '{default: '0};
    scr_w = (cols_reg < 1) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
    scr_h = (rows_reg < 1) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
    if (cur_col >= scr_w) cur_col = scr_w - 1;
    if (cur_row >= scr_h) cur_row = scr_h - 1;
    case (r.op)
      OP_TTY: begin
        line_att = TTY_ATTR;
        case (r.ch)
          CH_CR: cur_col = 0;
          CH_LF: begin
            line_att = shadow_cells[cell_pos(cur_col, cur_row)][15:8];
            cur_row++;
            cur_col = 0;
          end
          CH_BS: if (cur_col > 0) cur_col--;
          CH_TAB: begin
            do begin
              put_shadow(CH_SPACE);
              settle_shadow(TTY_ATTR);
            end while (cur_col % 8 != 0);
          end
          CH_BEL: v.bell = 1'b1;
          default: put_shadow(r.ch);
        endcase
        if (r.ch != CH_TAB) settle_shadow(line_att);
      end
      OP_SCR_UP, OP_SCR_DN: begin
        v.ignored = !scroll_shadow(r.left, r.top, r.right, r.bottom, r.op == OP_SCR_UP,
                                   r.cnt, r.attr);
      end
      OP_SET_CUR: begin
        if (r.ncol >= scr_w || r.nrow >= scr_h) v.ignored = 1'b1;
        else begin
          cur_col = r.ncol;
          cur_row = r.nrow;
        end
      end
      default: ;
    endcase
    cur_cell = shadow_cells[cell_pos(cur_col, cur_row)];
    v.cx = 8'(cur_col);
    v.cy = 6'(cur_row);
    v.ch = cur_cell[7:0];
    v.attr = cur_cell[15:8];
    return v;
  endfunction

  // Send one request; its view is predicted at the edge that accepts it
  task automatic send_request(tty_req_t r);
    int unsigned gap;
    push <= 1'b1;
    op_i <= r.op;
    char_code_i <= r.ch;
    fill_attr_i <= r.attr;
    line_count_i <= r.cnt;
    win_left_i <= r.left;
    win_top_i <= r.top;
    win_right_i <= r.right;
    win_bottom_i <= r.bottom;
    new_col_i <= r.ncol;
    new_row_i <= r.nrow;
    do @(posedge clk_i); while (full);
    pending_views.push_back(predict_view(r));
    requests_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  // Result side: random pops, each popped view checked against the oldest expectation
  always @(posedge clk_i) begin
    screen_view_t w;
    if (rst_ni && pop && !empty) begin
      views_checked++;
      if (pending_views.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = pending_views.pop_front();
        if (cursor_x_o !== w.cx) report_mismatch("cursor_x", cursor_x_o, w.cx);
        if (cursor_y_o !== w.cy) report_mismatch("cursor_y", cursor_y_o, w.cy);
        if (cell_char_o !== w.ch) report_mismatch("cell_char", cell_char_o, w.ch);
        if (cell_attr_o !== w.attr) report_mismatch("cell_attr", cell_attr_o, w.attr);
        if (bell_o !== w.bell) report_mismatch("bell", bell_o, w.bell);
        if (ignored_o !== w.ignored) report_mismatch("ignored", ignored_o, w.ignored);
      end
    end
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic drain_views();
    push <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Screen registers are written only while the engine is idle
  task automatic set_screen(int unsigned c, int unsigned r, int unsigned m);
    drain_views();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_COLS;
    cfg_data_i <= 8'(c);
    @(posedge clk_i);
    cfg_idx_i <= CFG_ROWS;
    cfg_data_i <= 8'(r);
    @(posedge clk_i);
    cfg_idx_i <= CFG_MONO;
    cfg_data_i <= 8'(m);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cols_reg = c & 32'hff;
    rows_reg = r & 32'h7f;
    mono_reg = m & 32'h1;
  endtask

  function automatic tty_req_t mk_req(logic [2:0] op, logic [7:0] ch = 8'h41);
    tty_req_t r;
    r = '{op: op, ch: ch, attr: 8'h1e, cnt: 8'd1, left: 8'd0, top: 8'd0,
          right: 8'd255, bottom: 8'd255, ncol: 8'd0, nrow: 8'd0};
    return r;
  endfunction

  function automatic tty_req_t mk_scroll(logic [2:0] op, int l, int t, int rr, int b,
                                         int c, int a);
    tty_req_t r;
    r = mk_req(op);
    r.left = 8'(l); r.top = 8'(t); r.right = 8'(rr); r.bottom = 8'(b);
    r.cnt = 8'(c); r.attr = 8'(a);
    return r;
  endfunction

  function automatic tty_req_t mk_cursor(int c, int r);
    tty_req_t q;
    q = mk_req(OP_SET_CUR);
    q.ncol = 8'(c);
    q.nrow = 8'(r);
    return q;
  endfunction

  // Control codes, wrap, bottom scroll, window cases and unknown ops
  task automatic test_directed();
    send_request(mk_req(OP_TTY, 8'h41));
    send_request(mk_req(OP_TTY, 8'hff));
    send_request(mk_req(OP_TTY, 8'h00));
    send_request(mk_req(OP_TTY, CH_BEL));
    send_request(mk_req(OP_TTY, CH_TAB));
    send_request(mk_req(OP_TTY, CH_BS));
    send_request(mk_req(OP_TTY, CH_CR));
    send_request(mk_req(OP_TTY, CH_BS));
    send_request(mk_scroll(OP_SCR_UP, 0, 0, 3, 0, 0, 8'h5a));
    send_request(mk_req(OP_TTY, CH_LF));
    send_request(mk_cursor(79, 24));
    send_request(mk_req(OP_TTY, 8'h7a));
    send_request(mk_cursor(255, 255));
    send_request(mk_cursor(0, 24));
    send_request(mk_scroll(OP_SCR_UP, 0, 24, 255, 255, 0, 8'hc3));
    send_request(mk_req(OP_TTY, CH_LF));
    send_request(mk_req(OP_READ));
    send_request(mk_scroll(OP_SCR_DN, 0, 0, 79, 24, 3, 8'h00));
    send_request(mk_scroll(OP_SCR_UP, 2, 1, 10, 5, 200, 8'hff));
    send_request(mk_scroll(OP_SCR_DN, 9, 0, 8, 5, 1, 8'h11));
    send_request(mk_scroll(OP_SCR_UP, 0, 30, 5, 255, 1, 8'h11));
    send_request(mk_req(3'd5));
    send_request(mk_req(3'd6));
    send_request(mk_req(3'd7));
  endtask

  // Monochrome blank rule
  task automatic test_mono_blank();
    set_screen(20, 6, 1);
    send_request(mk_scroll(OP_SCR_UP, 0, 0, 255, 255, 0, 8'h13));
    send_request(mk_scroll(OP_SCR_DN, 0, 0, 5, 3, 1, 8'h70));
    send_request(mk_scroll(OP_SCR_UP, 0, 0, 5, 3, 2, 8'h8f));
    send_request(mk_scroll(OP_SCR_DN, 0, 0, 5, 3, 1, 8'h06));
  endtask

  // Largest, smallest and out-of-range screen sizes; cursor pulled back on screen
  task automatic test_size_extremes();
    set_screen(132, 64, 0);
    send_request(mk_cursor(131, 63));
    send_request(mk_req(OP_TTY, 8'h58));
    send_request(mk_scroll(OP_SCR_DN, 0, 0, 255, 255, 1, 8'h21));
    set_screen(0, 0, 0);
    send_request(mk_req(OP_READ));
    send_request(mk_req(OP_TTY, CH_TAB));
    send_request(mk_req(OP_TTY, CH_LF));
    set_screen(255, 127, 0);
    send_request(mk_cursor(131, 63));
    set_screen(1, 64, 1);
    send_request(mk_req(OP_TTY, 8'h31));
    send_request(mk_cursor(0, 63));
    send_request(mk_req(OP_TTY, CH_LF));
  endtask

  function automatic tty_req_t random_request();
    tty_req_t   r;
    int unsigned pick;
    logic [7:0] ctl [5];
    ctl = '{CH_CR, CH_LF, CH_BS, CH_TAB, CH_BEL};
    r = '{op: 3'($urandom), ch: 8'($urandom), attr: 8'($urandom), cnt: 8'($urandom),
          left: 8'($urandom), top: 8'($urandom), right: 8'($urandom),
          bottom: 8'($urandom), ncol: 8'($urandom), nrow: 8'($urandom)};
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.op = OP_TTY;
      if ($urandom_range(0, 99) < 40) r.ch = ctl[$urandom_range(0, 4)];
    end else if (pick < 75) begin
      r.op = $urandom_range(0, 1) ? OP_SCR_UP : OP_SCR_DN;
      if ($urandom_range(0, 99) < 80) begin
        r.left = 8'($urandom_range(0, scr_w));
        r.top = 8'($urandom_range(0, scr_h));
        r.right = 8'($urandom_range(0, scr_w + 2));
        r.bottom = 8'($urandom_range(0, scr_h + 2));
        r.cnt = 8'($urandom_range(0, scr_h + 1));
      end
    end else if (pick < 90) begin
      r.op = OP_SET_CUR;
      if ($urandom_range(0, 99) < 80) begin
        r.ncol = 8'($urandom_range(0, scr_w));
        r.nrow = 8'($urandom_range(0, scr_h));
      end
    end else if (pick < 96) begin
      r.op = OP_READ;
    end else begin
      r.op = 3'($urandom_range(5, 7));
    end
    return r;
  endfunction

  // Random phases at varied screen sizes under one idling pattern
  task automatic test_random_traffic(int unsigned s_pct, int unsigned r_pct, bit hold_off);
    int unsigned c, rw;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin c = 80; rw = 25; end
        5: begin c = $urandom_range(100, 255); rw = $urandom_range(40, 127); end
        default: begin c = $urandom_range(1, 24); rw = $urandom_range(1, 10); end
      endcase
      set_screen(c, rw, $urandom_range(0, 1));
      scr_w = (c > MAX_COLS) ? MAX_COLS : c;
      scr_h = (rw > MAX_ROWS) ? MAX_ROWS : rw;
      for (int k = 0; k < ((ph == 5) ? 12 : 72); k++) begin
        if (hold_off && k == 30) drain_views();
        send_request(random_request());
      end
    end
  endtask

  initial begin
    for (int i = 0; i < CELL_COUNT; i++) shadow_cells[i] = BLANK_CELL;
    cols_reg = 80;
    rows_reg = 25;
    mono_reg = 0;
    cur_col = 0;
    cur_row = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_mono_blank();
    test_size_extremes();
    test_random_traffic(16, 63, 1'b1);
    test_random_traffic(63, 16, 1'b0);
    test_random_traffic(0, 0, 1'b0);
    drain_views();
    repeat (100) @(posedge clk_i);
    $display("Ran %0d requests, checked %0d results", requests_sent, views_checked);
    $display("Covered control codes, wrap, window scrolls, mono blanks and size extremes");
    if (mismatches == 0 && pending_views.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: text_mode_teletype_scroll_engine.f
rtl/core/ttsc_pkg.sv
rtl/core/ttsc_front.sv
rtl/core/ttsc_cmdq.sv
rtl/core/ttsc_back.sv
rtl/core/text_mode_teletype_scroll_engine.sv
tb/tb_top.sv
